@@ rtl/hermite_expansion_coefficients_core_defines.svh @@
// Assertion helpers shared by the files that check this core.
`ifndef HERMITE_EXPANSION_COEFFICIENTS_CORE_DEFINES_SVH
`define HERMITE_EXPANSION_COEFFICIENTS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HEC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hec_pkg.sv @@
package hec_pkg;

  localparam int MAX_ORDER = 2;
  localparam int KDIM      = 2 * MAX_ORDER + 1;
  localparam int ODIM      = MAX_ORDER + 1;
  localparam int DEPTH     = ODIM * ODIM * KDIM;
  localparam int AW        = $clog2(DEPTH);
  localparam int OW        = 2;
  localparam int KW        = 3;
  localparam int ACC_W     = 51;
  localparam int DIV_W     = 64;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef logic [OW-1:0] ord_t;
  typedef logic [KW-1:0] kidx_t;
  typedef logic [AW-1:0] addr_t;

  typedef struct packed {
    logic signed [31:0] im;
    logic signed [31:0] re;
  } cfix_t;

  typedef enum logic [2:0] {
    ASEL_SRE, ASEL_SIM, ASEL_HRE, ASEL_HIM, ASEL_GRE, ASEL_GIM, ASEL_KP1
  } asel_t;

  typedef enum logic [1:0] {
    BSEL_PRE, BSEL_PIM, BSEL_GRE, BSEL_GIM
  } bsel_t;

  typedef enum logic [1:0] {
    DST_RE, DST_IM, DST_DEN_LD, DST_DEN_ADD
  } dst_t;

  typedef struct packed {
    asel_t a;
    bsel_t b;
    dst_t  dst;
    logic  neg;
    logic  rnd;
  } mul_op_t;

  typedef struct packed {
    logic    load_req;
    logic    mul_valid;
    mul_op_t mul_op;
    kidx_t   kp1;
    logic    use_sb;
    logic    acc_clr;
    logic    p_load;
    logic    p_mask;
    addr_t   ram_raddr;
    logic    ram_we;
    addr_t   ram_waddr;
    logic    wr_one;
    logic    div_start;
    logic    div_im;
    logic    h_load;
    logic    h_im;
    logic    h_sat;
    logic    out_load;
    logic    out_mask;
  } hec_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
  } hec_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DEN0, ST_DEN1, ST_DEN_DRAIN, ST_RECIP, ST_DIV_RE, ST_DIV_IM,
    ST_INIT, ST_ENT_SEL, ST_TERM, ST_RD, ST_LD, ST_MUL, ST_DRAIN, ST_WR,
    ST_EM_RD, ST_EM_LD, ST_EM_WAIT
  } state_t;

  typedef enum logic [1:0] {
    TERM_S, TERM_H, TERM_K, TERM_END
  } term_t;

  function automatic addr_t entry_addr(input ord_t a, input ord_t b, input kidx_t k);
    int unsigned idx;
    idx = int'(a) * (ODIM * KDIM) + int'(b) * KDIM + int'(k);
    return idx[AW-1:0];
  endfunction

  function automatic ord_t clamp_order(input ord_t o);
    if (int'(o) > MAX_ORDER) return OW'(MAX_ORDER);
    return o;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    if (&x[ACC_W-1:31] || ~|x[ACC_W-1:31]) return x[31:0];
    return x[ACC_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

endpackage

@@ rtl/hec_ram.sv @@
module hec_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 45
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hec_div.sv @@
module hec_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hec_pkg::DIV_W-1:0]   num,
  input  logic [hec_pkg::DIV_W-1:0]   den,
  output logic                        done,
  output logic [hec_pkg::DIV_W-1:0]   quo
);

  localparam int CW = $clog2(hec_pkg::DIV_W);

  logic                      busy;
  logic [CW-1:0]             cnt;
  logic [hec_pkg::DIV_W:0]   rem;
  logic [hec_pkg::DIV_W:0]   rem_sh;
  logic [hec_pkg::DIV_W:0]   rem_next;
  logic                      ge;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of the quotient register as the quotient bits shift in.
  always_comb begin
    rem_sh   = {rem[hec_pkg::DIV_W-1:0], quo[hec_pkg::DIV_W-1]};
    ge       = rem_sh >= {1'b0, den};
    rem_next = ge ? rem_sh - {1'b0, den} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[hec_pkg::DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(hec_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/hec_dp.sv @@
module hec_dp (
  input  logic                clk,
  input  logic                rst,
  input  hec_pkg::hec_cmd_t   cmd,
  input  logic signed [31:0]  gamma_re,
  input  logic signed [31:0]  gamma_im,
  input  logic signed [31:0]  center_re,
  input  logic signed [31:0]  center_im,
  input  logic signed [31:0]  pos_a,
  input  logic signed [31:0]  pos_b,
  output hec_pkg::hec_stat_t  stat,
  output logic signed [31:0]  coef_re,
  output logic signed [31:0]  coef_im
);

  hec_pkg::cfix_t g, sa, sb, h, p, sx, wdata, rdata;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod_full, prod, prod_rnd;
  hec_pkg::mul_op_t prod_op;
  logic prod_vld;
  logic signed [hec_pkg::ACC_W-1:0] acc_re, acc_im, term, term_s;
  logic [63:0] den, num, quo;
  logic [31:0] mag;
  logic signed [32:0] dsa, dsb;
  logic div_done, hneg, qbig;
  logic signed [31:0] hval;

  assign dsa = {center_re[31], center_re} - {pos_a[31], pos_a};
  assign dsb = {center_re[31], center_re} - {pos_b[31], pos_b};

  assign sx = cmd.use_sb ? sb : sa;

  always_comb begin
    unique case (cmd.mul_op.a)
      hec_pkg::ASEL_SRE: op_a = sx.re;
      hec_pkg::ASEL_SIM: op_a = sx.im;
      hec_pkg::ASEL_HRE: op_a = h.re;
      hec_pkg::ASEL_HIM: op_a = h.im;
      hec_pkg::ASEL_GRE: op_a = g.re;
      hec_pkg::ASEL_GIM: op_a = g.im;
      hec_pkg::ASEL_KP1: op_a = signed'({{(32 - hec_pkg::KW){1'b0}}, cmd.kp1});
      default:           op_a = '0;
    endcase
    unique case (cmd.mul_op.b)
      hec_pkg::BSEL_PRE: op_b = p.re;
      hec_pkg::BSEL_PIM: op_b = p.im;
      hec_pkg::BSEL_GRE: op_b = g.re;
      hec_pkg::BSEL_GIM: op_b = g.im;
      default:           op_b = '0;
    endcase
  end

  assign prod_full = op_a * op_b;

  // Products of Q16.16 values round to nearest at bit 16; the integer weight
  // on the higher term is taken exactly.
  assign prod_rnd = (prod + 64'sd32768) >>> 16;
  assign term     = prod_op.rnd ? prod_rnd[hec_pkg::ACC_W-1:0] : prod[hec_pkg::ACC_W-1:0];
  assign term_s   = prod_op.neg ? -term : term;

  // Magnitude of the selected part of g, placed at bit 31 of the dividend,
  // plus half the divisor so that the quotient rounds to nearest.
  always_comb begin
    mag = cmd.div_im ? g.im : g.re;
    if (mag[31]) begin
      mag = -mag;
    end
    num = {1'b0, mag, 31'b0} + {1'b0, den[63:1]};
  end

  hec_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // h = conj(g) / (2|g|^2): the imaginary part takes the opposite sign.
  always_comb begin
    hneg = cmd.h_im ? !g.im[31] : g.re[31];
    qbig = |quo[63:31];
    if (hneg) begin
      hval = qbig ? hec_pkg::SAT_MIN : -signed'(quo[31:0]);
    end else begin
      hval = qbig ? hec_pkg::SAT_MAX : signed'(quo[31:0]);
    end
  end

  always_comb begin
    if (cmd.wr_one) begin
      wdata.re = hec_pkg::ONE_Q16;
      wdata.im = '0;
    end else begin
      wdata.re = hec_pkg::sat32(acc_re);
      wdata.im = hec_pkg::sat32(acc_im);
    end
  end

  hec_ram #(
    .WIDTH ($bits(hec_pkg::cfix_t)),
    .DEPTH (hec_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (cmd.ram_waddr),
    .wdata (wdata),
    .raddr (cmd.ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      h        <= '0;
    end else begin
      prod_vld <= cmd.mul_valid;
      if (cmd.h_sat) begin
        h.re <= hec_pkg::SAT_MAX;
        h.im <= '0;
      end else if (cmd.h_load) begin
        if (cmd.h_im) begin
          h.im <= hval;
        end else begin
          h.re <= hval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      g.re  <= gamma_re;
      g.im  <= gamma_im;
      sa.re <= hec_pkg::sat32(signed'({{(hec_pkg::ACC_W - 33){dsa[32]}}, dsa}));
      sa.im <= center_im;
      sb.re <= hec_pkg::sat32(signed'({{(hec_pkg::ACC_W - 33){dsb[32]}}, dsb}));
      sb.im <= center_im;
    end
    prod    <= prod_full;
    prod_op <= cmd.mul_op;
    if (cmd.p_load) begin
      p <= cmd.p_mask ? '0 : rdata;
    end
    if (cmd.acc_clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end
    if (prod_vld) begin
      unique case (prod_op.dst)
        hec_pkg::DST_RE:      acc_re <= acc_re + term_s;
        hec_pkg::DST_IM:      acc_im <= acc_im + term_s;
        hec_pkg::DST_DEN_LD:  den    <= prod;
        hec_pkg::DST_DEN_ADD: den    <= den + prod;
        default:              den    <= den;
      endcase
    end
    if (cmd.out_load) begin
      coef_re <= cmd.out_mask ? '0 : rdata.re;
      coef_im <= cmd.out_mask ? '0 : rdata.im;
    end
  end

  assign stat.den_zero = (den == '0);
  assign stat.div_done = div_done;

endmodule

@@ rtl/hec_ctrl.sv @@
module hec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hec_pkg::ord_t       order_a,
  input  hec_pkg::ord_t       order_b,
  input  hec_pkg::hec_stat_t  stat,
  output hec_pkg::hec_cmd_t   cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output hec_pkg::ord_t       idx_a,
  output hec_pkg::ord_t       idx_b,
  output hec_pkg::kidx_t      idx_k,
  output logic                last
);

  hec_pkg::state_t state, state_next;
  hec_pkg::term_t  t, t_next;
  hec_pkg::ord_t   na, na_next, nb, nb_next, a, a_next, b, b_next;
  hec_pkg::kidx_t  nk, n, n_next, k, k_next, j, bc;
  logic [1:0]      op, op_next;
  logic            out_valid_next, last_next;
  hec_pkg::ord_t   idx_a_next, idx_b_next, src_a, src_b;
  hec_pkg::kidx_t  idx_k_next;
  logic            op_last;

  function automatic hec_pkg::mul_op_t term_op(input hec_pkg::term_t tt, input logic [1:0] o);
    hec_pkg::mul_op_t m;
    hec_pkg::asel_t   xre, xim;
    xre = (tt == hec_pkg::TERM_H) ? hec_pkg::ASEL_HRE : hec_pkg::ASEL_SRE;
    xim = (tt == hec_pkg::TERM_H) ? hec_pkg::ASEL_HIM : hec_pkg::ASEL_SIM;
    m.rnd = (tt != hec_pkg::TERM_K);
    m.neg = 1'b0;
    if (tt == hec_pkg::TERM_K) begin
      m.a   = hec_pkg::ASEL_KP1;
      m.b   = o[0] ? hec_pkg::BSEL_PIM : hec_pkg::BSEL_PRE;
      m.dst = o[0] ? hec_pkg::DST_IM : hec_pkg::DST_RE;
    end else begin
      unique case (o)
        2'd0: begin m.a = xre; m.b = hec_pkg::BSEL_PRE; m.dst = hec_pkg::DST_RE; end
        2'd1: begin
          m.a = xim; m.b = hec_pkg::BSEL_PIM; m.dst = hec_pkg::DST_RE; m.neg = 1'b1;
        end
        2'd2: begin m.a = xre; m.b = hec_pkg::BSEL_PIM; m.dst = hec_pkg::DST_IM; end
        default: begin m.a = xim; m.b = hec_pkg::BSEL_PRE; m.dst = hec_pkg::DST_IM; end
      endcase
    end
    return m;
  endfunction

  assign nk = hec_pkg::KW'(na) + hec_pkg::KW'(nb);
  assign bc = n - hec_pkg::KW'(a);

  // The lower-order neighbour: step back in a when a is non-zero, else in b.
  assign src_a = (a != '0) ? a - 1'b1 : a;
  assign src_b = (a != '0) ? bc[hec_pkg::OW-1:0] : bc[hec_pkg::OW-1:0] - 1'b1;

  always_comb begin
    unique case (t)
      hec_pkg::TERM_H: j = k - 1'b1;
      hec_pkg::TERM_K: j = k + 1'b1;
      default:         j = k;
    endcase
  end

  assign op_last = (t == hec_pkg::TERM_K) ? (op == 2'd1) : (op == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hec_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    t     <= t_next;
    na    <= na_next;
    nb    <= nb_next;
    n     <= n_next;
    a     <= a_next;
    b     <= b_next;
    k     <= k_next;
    op    <= op_next;
    idx_a <= idx_a_next;
    idx_b <= idx_b_next;
    idx_k <= idx_k_next;
    last  <= last_next;
  end

  always_comb begin
    state_next     = state;
    t_next         = t;
    na_next        = na;
    nb_next        = nb;
    n_next         = n;
    a_next         = a;
    b_next         = b;
    k_next         = k;
    op_next        = op;
    out_valid_next = out_valid;
    idx_a_next     = idx_a;
    idx_b_next     = idx_b;
    idx_k_next     = idx_k;
    last_next      = last;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul_op     = term_op(t, op);
    cmd.kp1        = k + 1'b1;
    cmd.use_sb     = (a == '0);
    cmd.ram_waddr  = hec_pkg::entry_addr(a, bc[hec_pkg::OW-1:0], k);
    cmd.ram_raddr  = hec_pkg::entry_addr(src_a, src_b, j);

    unique case (state)
      hec_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          na_next      = hec_pkg::clamp_order(order_a);
          nb_next      = hec_pkg::clamp_order(order_b);
          state_next   = hec_pkg::ST_DEN0;
        end
      end
      hec_pkg::ST_DEN0: begin
        cmd.mul_valid  = 1'b1;
        cmd.mul_op.a   = hec_pkg::ASEL_GRE;
        cmd.mul_op.b   = hec_pkg::BSEL_GRE;
        cmd.mul_op.dst = hec_pkg::DST_DEN_LD;
        state_next     = hec_pkg::ST_DEN1;
      end
      hec_pkg::ST_DEN1: begin
        cmd.mul_valid  = 1'b1;
        cmd.mul_op.a   = hec_pkg::ASEL_GIM;
        cmd.mul_op.b   = hec_pkg::BSEL_GIM;
        cmd.mul_op.dst = hec_pkg::DST_DEN_ADD;
        state_next     = hec_pkg::ST_DEN_DRAIN;
      end
      hec_pkg::ST_DEN_DRAIN: state_next = hec_pkg::ST_RECIP;
      hec_pkg::ST_RECIP: begin
        if (stat.den_zero) begin
          cmd.h_sat  = 1'b1;
          state_next = hec_pkg::ST_INIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = hec_pkg::ST_DIV_RE;
        end
      end
      hec_pkg::ST_DIV_RE: begin
        if (stat.div_done) begin
          cmd.h_load    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_im    = 1'b1;
          state_next    = hec_pkg::ST_DIV_IM;
        end
      end
      hec_pkg::ST_DIV_IM: begin
        if (stat.div_done) begin
          cmd.h_load = 1'b1;
          cmd.h_im   = 1'b1;
          state_next = hec_pkg::ST_INIT;
        end
      end
      hec_pkg::ST_INIT: begin
        cmd.ram_we    = 1'b1;
        cmd.wr_one    = 1'b1;
        cmd.ram_waddr = hec_pkg::entry_addr('0, '0, '0);
        n_next        = hec_pkg::KW'(1);
        a_next        = '0;
        state_next    = hec_pkg::ST_ENT_SEL;
      end
      // Walks the anti-diagonal a + b = n for the next entry inside the box.
      hec_pkg::ST_ENT_SEL: begin
        if (n > nk) begin
          a_next     = '0;
          b_next     = '0;
          k_next     = '0;
          state_next = hec_pkg::ST_EM_RD;
        end else if (a > na || hec_pkg::KW'(a) > n) begin
          n_next = n + 1'b1;
          a_next = '0;
        end else if (bc > hec_pkg::KW'(nb)) begin
          a_next = a + 1'b1;
        end else begin
          cmd.acc_clr = 1'b1;
          k_next      = '0;
          t_next      = hec_pkg::TERM_S;
          state_next  = hec_pkg::ST_TERM;
        end
      end
      hec_pkg::ST_TERM: begin
        unique case (t)
          hec_pkg::TERM_S: state_next = hec_pkg::ST_RD;
          hec_pkg::TERM_H: begin
            if (k != '0) state_next = hec_pkg::ST_RD;
            else t_next = hec_pkg::TERM_K;
          end
          hec_pkg::TERM_K: begin
            if (k + 1'b1 <= nk) state_next = hec_pkg::ST_RD;
            else t_next = hec_pkg::TERM_END;
          end
          default: state_next = hec_pkg::ST_DRAIN;
        endcase
      end
      hec_pkg::ST_RD: state_next = hec_pkg::ST_LD;
      hec_pkg::ST_LD: begin
        // Entries of the previous order beyond its own highest index are zero.
        cmd.p_load = 1'b1;
        cmd.p_mask = (j >= n);
        op_next    = '0;
        state_next = hec_pkg::ST_MUL;
      end
      hec_pkg::ST_MUL: begin
        cmd.mul_valid = 1'b1;
        op_next       = op + 1'b1;
        if (op_last) begin
          t_next     = (t == hec_pkg::TERM_S) ? hec_pkg::TERM_H :
                       (t == hec_pkg::TERM_H) ? hec_pkg::TERM_K : hec_pkg::TERM_END;
          state_next = hec_pkg::ST_TERM;
        end
      end
      hec_pkg::ST_DRAIN: state_next = hec_pkg::ST_WR;
      hec_pkg::ST_WR: begin
        cmd.ram_we = 1'b1;
        if (k == n) begin
          a_next     = a + 1'b1;
          state_next = hec_pkg::ST_ENT_SEL;
        end else begin
          cmd.acc_clr = 1'b1;
          k_next      = k + 1'b1;
          t_next      = hec_pkg::TERM_S;
          state_next  = hec_pkg::ST_TERM;
        end
      end
      hec_pkg::ST_EM_RD: begin
        cmd.ram_raddr = hec_pkg::entry_addr(a, b, k);
        state_next    = hec_pkg::ST_EM_LD;
      end
      hec_pkg::ST_EM_LD: begin
        cmd.out_load   = 1'b1;
        cmd.out_mask   = k > (hec_pkg::KW'(a) + hec_pkg::KW'(b));
        out_valid_next = 1'b1;
        idx_a_next     = a;
        idx_b_next     = b;
        idx_k_next     = k;
        last_next      = (a == na) && (b == nb) && (k == nk);
        state_next     = hec_pkg::ST_EM_WAIT;
      end
      hec_pkg::ST_EM_WAIT: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (last) begin
            state_next = hec_pkg::ST_IDLE;
          end else begin
            state_next = hec_pkg::ST_EM_RD;
            if (k == nk) begin
              k_next = '0;
              if (b == nb) begin
                b_next = '0;
                a_next = a + 1'b1;
              end else begin
                b_next = b + 1'b1;
              end
            end else begin
              k_next = k + 1'b1;
            end
          end
        end
      end
      default: state_next = hec_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/hermite_expansion_coefficients_core.sv @@
// Channel  Dir  Fields (tdata from bit 0 up)                                  Width
// s_axis   in   gamma_re, gamma_im, center_re, center_im, pos_a, pos_b,         200
//               order_a, order_b, zero fill
// m_axis   out  idx_a, idx_b, idx_k, coef_re, coef_im, zero fill; tlast = last  72
//
// One request at a time. Set-up is dominated by the two 64-step divisions of the
// bit-serial divider that forms 1/(2g).
// Each computed coefficient is then formed on the single shared 32x32 multiplier,
// after its (a, b) pair has been selected.
// Each emitted coefficient is read from the table and held until the output takes it.
// Synchronous active-high reset returns the core to idle; the table needs no clearing.
// s_axis_tready is high only while idle.
`include "hermite_expansion_coefficients_core_defines.svh"

module hermite_expansion_coefficients_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // gamma_re, gamma_im, center_re, center_im, pos_a, pos_b, order_a, order_b
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // idx_a, idx_b, idx_k, coef_re, coef_im
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  hec_pkg::hec_cmd_t  cmd;
  hec_pkg::hec_stat_t stat;
  hec_pkg::ord_t      idx_a, idx_b;
  hec_pkg::kidx_t     idx_k;
  logic signed [31:0] coef_re, coef_im;

  hec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .order_a   (s_axis_tdata[193:192]),
    .order_b   (s_axis_tdata[195:194]),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .idx_a     (idx_a),
    .idx_b     (idx_b),
    .idx_k     (idx_k),
    .last      (m_axis_tlast)
  );

  hec_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .gamma_re  (s_axis_tdata[31:0]),
    .gamma_im  (s_axis_tdata[63:32]),
    .center_re (s_axis_tdata[95:64]),
    .center_im (s_axis_tdata[127:96]),
    .pos_a     (s_axis_tdata[159:128]),
    .pos_b     (s_axis_tdata[191:160]),
    .stat      (stat),
    .coef_re   (coef_re),
    .coef_im   (coef_im)
  );

  assign m_axis_tdata = {1'b0, coef_im, coef_re, idx_k, idx_b, idx_a};

  `HEC_ASSERT_SAME(a_no_overlap, s_axis_tvalid && s_axis_tready, !m_axis_tvalid,
                   "request taken while a coefficient was pending")
  `HEC_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "core still ready after taking a request")
  `HEC_ASSERT_NEXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                   !m_axis_tvalid, "coefficient offered after the final one")
  `HEC_ASSERT_SAME(a_high_k_zero,
                   m_axis_tvalid && (idx_k > (3'(idx_a) + 3'(idx_b))),
                   coef_re == '0 && coef_im == '0,
                   "non-zero coefficient above the total order")

endmodule
